>>> sv/tkgs_pkg.sv
// ----------------------------------------------------------------------------
// tkgs_pkg: shared types and constants of the top-k group sum tracker
// Holds the keep size, the field widths, the command codes, the slot
// operation codes and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tkgs_pkg;

	// Number of slots built into the keep.
	localparam int MAX_SLOTS = 8;

	// Widths of the fields.
	localparam int SUM_W   = 32;
	localparam int VAL_W   = 16;
	localparam int TOT_W   = 35;
	localparam int KEPT_W  = 4;
	localparam int KCNT_W  = 4;
	localparam int CNT_W   = $clog2(MAX_SLOTS + 1);

	// Reset value of the keep_count register.
	localparam logic [KCNT_W-1:0] KEEP_RESET = 4'd3;

	// Input commands.
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// What the row of slot cells does in a cycle.
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REPLACE
	} op_t;

	// Keep status: number of kept sums and their total.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [TOT_W-1:0] total;
	} keep_stat_t;

	// One result beat.
	typedef struct packed {
		logic [SUM_W-1:0]  best_group;
		logic [TOT_W-1:0]  top_total;
		logic [KEPT_W-1:0] kept;
		logic [SUM_W-1:0]  group_running;
		logic              saturated;
	} res_t;

endpackage

`default_nettype wire

>>> sv/tkgs_cell.sv
// ----------------------------------------------------------------------------
// tkgs_cell: one slot of the sorted keep
// Holds one kept sum. The row is kept in ascending order; on an insert
// or a replace each cell takes its own value, a neighbor's or the offer.
// ----------------------------------------------------------------------------
`default_nettype none

module tkgs_cell (
	input  wire logic                        clk,
	input  wire tkgs_pkg::op_t               op,
	input  wire logic [tkgs_pkg::SUM_W-1:0]  offer,
	input  wire logic                        valid,
	input  wire logic                        left_lt,
	input  wire logic [tkgs_pkg::SUM_W-1:0]  left_val,
	input  wire logic                        right_lt,
	input  wire logic [tkgs_pkg::SUM_W-1:0]  right_val,
	output logic      [tkgs_pkg::SUM_W-1:0]  val,
	output logic                             lt
);

	logic [tkgs_pkg::SUM_W-1:0] slot_q;
	logic [tkgs_pkg::SUM_W-1:0] slot_d;

	assign val = slot_q;
	assign lt  = valid && (slot_q < offer);

	always_comb begin
		slot_d = slot_q;
		case (op)
			tkgs_pkg::OP_INSERT: begin
				// Values below the offer stay, the first cell at or above it
				// takes the offer, the rest move up by one.
				if (!lt) begin
					slot_d = left_lt ? offer : left_val;
				end
			end
			tkgs_pkg::OP_REPLACE: begin
				// The smallest drops out; values below the offer move down.
				if (right_lt) begin
					slot_d = right_val;
				end else if (lt) begin
					slot_d = offer;
				end
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

endmodule

`default_nettype wire

>>> sv/tkgs_keep.sv
// ----------------------------------------------------------------------------
// tkgs_keep: keep of the largest group sums
// A row of slot cells in ascending order with the kept count and the
// running total of the kept sums. Gives the status after this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tkgs_keep (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         clear,
	input  wire logic                         close,
	input  wire logic [tkgs_pkg::SUM_W-1:0]   offer,
	input  wire logic [tkgs_pkg::KCNT_W-1:0]  keep_count,
	output tkgs_pkg::keep_stat_t              stat_d
);

	localparam int NS = tkgs_pkg::MAX_SLOTS;
	localparam int CW = tkgs_pkg::CNT_W;
	localparam int TW = tkgs_pkg::TOT_W;
	localparam int SW = tkgs_pkg::SUM_W;

	logic [CW-1:0]  count_q;
	logic [TW-1:0]  total_q;
	logic [CW-1:0]  cap;
	tkgs_pkg::op_t  op;
	logic [SW-1:0]  slot_val [NS];
	logic           slot_lt  [NS];

	// Capacity is keep_count limited to the built slot count.
	always_comb begin
		if (32'(keep_count) > 32'(NS)) begin
			cap = CW'(NS);
		end else begin
			cap = CW'(keep_count);
		end
	end

	// Slot 0 always holds the smallest kept sum.
	always_comb begin
		op           = tkgs_pkg::OP_HOLD;
		stat_d.count = count_q;
		stat_d.total = total_q;
		if (clear) begin
			stat_d.count = '0;
			stat_d.total = '0;
		end else if (close) begin
			if (count_q < cap) begin
				op           = tkgs_pkg::OP_INSERT;
				stat_d.count = count_q + CW'(1);
				stat_d.total = total_q + TW'(offer);
			end else if (count_q == cap && cap != '0 && offer > slot_val[0]) begin
				op           = tkgs_pkg::OP_REPLACE;
				stat_d.total = total_q + TW'(offer) - TW'(slot_val[0]);
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cell
		logic          valid;
		logic          left_lt;
		logic [SW-1:0] left_val;
		logic          right_lt;
		logic [SW-1:0] right_val;

		assign valid = CW'(i) < count_q;

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_val = offer;
		end else begin : g_mid
			assign left_lt  = slot_lt[i-1];
			assign left_val = slot_val[i-1];
		end

		if (i == NS - 1) begin : g_last
			assign right_lt  = 1'b0;
			assign right_val = '0;
		end else begin : g_inner
			assign right_lt  = slot_lt[i+1];
			assign right_val = slot_val[i+1];
		end

		tkgs_cell u_cell (
			.clk       (clk),
			.op        (op),
			.offer     (offer),
			.valid     (valid),
			.left_lt   (left_lt),
			.left_val  (left_val),
			.right_lt  (right_lt),
			.right_val (right_val),
			.val       (slot_val[i]),
			.lt        (slot_lt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else begin
			count_q <= stat_d.count;
			total_q <= stat_d.total;
		end
	end

endmodule

`default_nettype wire

>>> sv/top_k_group_sum_tracker.sv
// ----------------------------------------------------------------------------
// top_k_group_sum_tracker: streaming top-k selection over group sums
// Sums item values into groups, keeps the largest closed group sums in a
// sorted row of slot cells and reports the state after every beat.
// ----------------------------------------------------------------------------
//   Input channel (in_valid/in_stall, cmd, value): one beat per item. cmd
//   adds value to the open group, closes the group and offers its sum to
//   the keep, clears all state, or does nothing.
//   Output channel (out_valid/out_stall): one result beat per input beat,
//   showing the largest group sum, the total and count of kept sums, the
//   open group sum and the saturation flag after that item.
//   keep_count is written through cfg_wr_en/cfg_wr_data; the user must do
//   so while no beat is in flight, as the block does not enforce it. It
//   takes effect on the next item. A result is registered as its item is
//   taken. One item is taken per cycle while in_stall is low, and its
//   state update, slot row insert or replace included, ends in that cycle.
//   Reset clears all state, empties the output buffer and sets keep_count
//   to 3. A stalled receiver holds the output beat; one more result goes to
//   a skid register, and in_stall rises only while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_group_sum_tracker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [tkgs_pkg::KCNT_W-1:0]  cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   cmd,
	input  wire logic [tkgs_pkg::VAL_W-1:0]   value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [tkgs_pkg::SUM_W-1:0]        best_group,
	output logic [tkgs_pkg::TOT_W-1:0]        top_total,
	output logic [tkgs_pkg::KEPT_W-1:0]       kept,
	output logic [tkgs_pkg::SUM_W-1:0]        group_running,
	output logic                              saturated
);

	localparam int SW = tkgs_pkg::SUM_W;

	// Configuration register.
	logic [tkgs_pkg::KCNT_W-1:0] keep_count_q;

	// Group state.
	logic [SW-1:0] open_sum_q;
	logic [SW-1:0] open_sum_d;
	logic [SW-1:0] largest_q;
	logic [SW-1:0] largest_d;
	logic          sat_q;
	logic          sat_d;
	logic [SW:0]   add_sum;

	// Output register and skid register.
	tkgs_pkg::res_t out_q;
	tkgs_pkg::res_t skid_q;
	tkgs_pkg::res_t res_d;
	logic           out_valid_q;
	logic           skid_valid_q;

	logic                 in_fire;
	logic                 out_fire;
	logic                 do_close;
	logic                 do_clear;
	tkgs_pkg::keep_stat_t stat_d;

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;
	assign do_close = in_fire && (cmd == tkgs_pkg::CMD_CLOSE);
	assign do_clear = in_fire && (cmd == tkgs_pkg::CMD_CLEAR);

	// The 33-bit add tells whether the open sum passes its ceiling.
	assign add_sum = {1'b0, open_sum_q} + {{(SW + 1 - tkgs_pkg::VAL_W){1'b0}}, value};

	always_comb begin
		open_sum_d = open_sum_q;
		largest_d  = largest_q;
		sat_d      = sat_q;
		if (in_fire) begin
			case (cmd)
				tkgs_pkg::CMD_ADD: begin
					if (add_sum[SW]) begin
						open_sum_d = '1;
						sat_d      = 1'b1;
					end else begin
						open_sum_d = add_sum[SW-1:0];
						if (add_sum[SW-1:0] == '1) begin
							sat_d = 1'b1;
						end
					end
				end
				tkgs_pkg::CMD_CLOSE: begin
					if (open_sum_q > largest_q) begin
						largest_d = open_sum_q;
					end
					open_sum_d = '0;
				end
				tkgs_pkg::CMD_CLEAR: begin
					open_sum_d = '0;
					largest_d  = '0;
					sat_d      = 1'b0;
				end
				default: begin
					open_sum_d = open_sum_q;
				end
			endcase
		end
	end

	tkgs_keep u_keep (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (do_clear),
		.close      (do_close),
		.offer      (open_sum_q),
		.keep_count (keep_count_q),
		.stat_d     (stat_d)
	);

	// The result shows the state after the item.
	always_comb begin
		res_d.best_group    = largest_d;
		res_d.top_total     = stat_d.total;
		res_d.kept          = tkgs_pkg::KEPT_W'(stat_d.count);
		res_d.group_running = open_sum_d;
		res_d.saturated     = sat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= tkgs_pkg::KEEP_RESET;
			open_sum_q   <= '0;
			largest_q    <= '0;
			sat_q        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				keep_count_q <= cfg_wr_data;
			end
			open_sum_q <= open_sum_d;
			largest_q  <= largest_d;
			sat_q      <= sat_d;
		end
	end

	// Output buffer: the output register refills from the skid register
	// first, then from a new result; a new result that finds the output
	// register held goes to the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire || !out_valid_q) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res_d;
			end
		end else if (in_fire) begin
			skid_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_group    = out_q.best_group;
	assign top_total     = out_q.top_total;
	assign kept          = out_q.kept;
	assign group_running = out_q.group_running;
	assign saturated     = out_q.saturated;

endmodule

`default_nettype wire

>>> tb/top_k_group_sum_tracker_check.sv
// ----------------------------------------------------------------------------
// top_k_group_sum_tracker_check: result checker for the group sum tracker
// Watches both channels and the keep_count write port. It keeps its own copy
// of the open group sum, the kept sums, the largest sum and the ceiling flag.
// For each input beat it queues the result that beat must produce, and it
// compares each output beat, field by field, with the oldest queued result.
// ----------------------------------------------------------------------------
module top_k_group_sum_tracker_check (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [tkgs_pkg::KCNT_W-1:0]  cfg_wr_data,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [1:0]                   cmd,
	input  wire logic [tkgs_pkg::VAL_W-1:0]   value,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic [tkgs_pkg::SUM_W-1:0]   best_group,
	input  wire logic [tkgs_pkg::TOT_W-1:0]   top_total,
	input  wire logic [tkgs_pkg::KEPT_W-1:0]  kept,
	input  wire logic [tkgs_pkg::SUM_W-1:0]   group_running,
	input  wire logic                         saturated,
	output int                                errors,
	output int                                waiting
);

	logic [tkgs_pkg::KCNT_W-1:0] keep_limit;
	logic [tkgs_pkg::SUM_W-1:0]  group_acc;
	logic [tkgs_pkg::SUM_W-1:0]  slot_sum [tkgs_pkg::MAX_SLOTS];
	int                          slots_used;
	logic [tkgs_pkg::SUM_W-1:0]  peak_sum;
	logic                        ceiling_hit;
	tkgs_pkg::res_t              expected_q [$];
	tkgs_pkg::res_t              seen;
	tkgs_pkg::res_t              want;
	int                          bad_beats;

	function void clear_state();
		group_acc = '0;
		for (int i = 0; i < tkgs_pkg::MAX_SLOTS; i++)
			slot_sum[i] = '0;
		slots_used  = 0;
		peak_sum    = '0;
		ceiling_hit = 1'b0;
	endfunction

	function void show(string tag, tkgs_pkg::res_t r);
		$display("%0t:   %s best %0d total %0d kept %0d running %0d sat %0b",
			$time, tag, r.best_group, r.top_total, r.kept, r.group_running,
			r.saturated);
	endfunction

	// Applies one beat to the local state and returns the result it shows.
	function tkgs_pkg::res_t advance_state(tkgs_pkg::cmd_t c,
		logic [tkgs_pkg::VAL_W-1:0] v);
		logic [tkgs_pkg::SUM_W:0]   wide;
		logic [tkgs_pkg::TOT_W-1:0] acc;
		int                         cap;
		int                         low;
		tkgs_pkg::res_t             r;
		case (c)
			tkgs_pkg::CMD_ADD: begin
				wide = {1'b0, group_acc} +
					{{(tkgs_pkg::SUM_W + 1 - tkgs_pkg::VAL_W){1'b0}}, v};
				if (wide >= {1'b0, {tkgs_pkg::SUM_W{1'b1}}}) begin
					group_acc   = '1;
					ceiling_hit = 1'b1;
				end else begin
					group_acc = wide[tkgs_pkg::SUM_W-1:0];
				end
			end
			tkgs_pkg::CMD_CLOSE: begin
				if (group_acc > peak_sum)
					peak_sum = group_acc;
				cap = (int'(keep_limit) > tkgs_pkg::MAX_SLOTS) ?
					tkgs_pkg::MAX_SLOTS : int'(keep_limit);
				if (slots_used < cap) begin
					slot_sum[slots_used] = group_acc;
					slots_used++;
				end else if (slots_used == cap && cap != 0) begin
					// On a tie for the smallest, the lowest slot loses.
					low = 0;
					for (int i = 1; i < cap; i++)
						if (slot_sum[i] < slot_sum[low])
							low = i;
					if (group_acc > slot_sum[low])
						slot_sum[low] = group_acc;
				end
				group_acc = '0;
			end
			tkgs_pkg::CMD_CLEAR: clear_state();
			default: ;
		endcase
		acc = '0;
		for (int i = 0; i < slots_used; i++)
			acc = acc + tkgs_pkg::TOT_W'(slot_sum[i]);
		r.best_group    = peak_sum;
		r.top_total     = acc;
		r.kept          = slots_used[tkgs_pkg::KEPT_W-1:0];
		r.group_running = group_acc;
		r.saturated     = ceiling_hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit = tkgs_pkg::KEEP_RESET;
			clear_state();
			expected_q.delete();
			bad_beats = 0;
			errors  <= 0;
			waiting <= 0;
		end else begin
			// Results leave only after their beat has been registered, so popping first
			// keeps a stray result from matching the beat taken at this edge.
			if (out_valid && !out_stall) begin
				seen = {best_group, top_total, kept, group_running, saturated};
				if (expected_q.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10) begin
						$display("%0t: result beat with nothing expected", $time);
						show("actual  ", seen);
					end
				end else begin
					want = expected_q.pop_front();
					if (seen.best_group !== want.best_group ||
						seen.top_total !== want.top_total ||
						seen.kept !== want.kept ||
						seen.group_running !== want.group_running ||
						seen.saturated !== want.saturated) begin
						bad_beats++;
						if (bad_beats <= 10) begin
							$display("%0t: wrong result", $time);
							show("expected", want);
							show("actual  ", seen);
						end
					end
				end
			end
			// A beat taken at this edge still sees the old keep_count.
			if (in_valid && !in_stall)
				expected_q = {expected_q, advance_state(tkgs_pkg::cmd_t'(cmd), value)};
			if (cfg_wr_en)
				keep_limit = cfg_wr_data;
			errors  <= bad_beats;
			waiting <= expected_q.size();
		end
	end

endmodule

>>> tb/top_k_group_sum_tracker_test.sv
// ----------------------------------------------------------------------------
// top_k_group_sum_tracker_test: testbench top of the group sum tracker
// Drives item beats and keep_count writes into the tracker and stalls its
// output at random; a checker beside the block predicts every result beat.
// A directed opening covers the corner cases, then random group sequences
// run under several keep sizes and idling patterns, including a long output
// hold-off and a run of large group sums.
// ----------------------------------------------------------------------------
module top_k_group_sum_tracker_test;

	// The output hold-off in cycles; long enough to fill the block and back up
	// the input channel many times over.
	localparam int HOLD_LEN = 200;

	// Every input is known from time zero; reset is held from the start.
	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_wr_en   = 1'b0;
	logic [tkgs_pkg::KCNT_W-1:0] cfg_wr_data = '0;
	logic                        in_valid    = 1'b0;
	logic [1:0]                  cmd         = tkgs_pkg::CMD_NONE;
	logic [tkgs_pkg::VAL_W-1:0]  value       = '0;
	logic                        out_stall   = 1'b0;

	logic                        in_stall;
	logic                        out_valid;
	logic [tkgs_pkg::SUM_W-1:0]  best_group;
	logic [tkgs_pkg::TOT_W-1:0]  top_total;
	logic [tkgs_pkg::KEPT_W-1:0] kept;
	logic [tkgs_pkg::SUM_W-1:0]  group_running;
	logic                        saturated;

	int errors;
	int waiting;

	// Idle rates of the two sides in percent of cycles. The run starts with
	// an occasionally idle sender and a mostly stalling receiver.
	int   send_gap_pct = 13;
	int   recv_gap_pct = 85;
	// The hold-off is requested once by the stimulus and counted out by the
	// receiver process on its own.
	logic hold_req  = 1'b0;
	logic hold_used = 1'b0;
	int   hold_left = 0;

	always #1 clk = ~clk;

	top_k_group_sum_tracker DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.best_group    (best_group),
		.top_total     (top_total),
		.kept          (kept),
		.group_running (group_running),
		.saturated     (saturated)
	);

	top_k_group_sum_tracker_check sum_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.best_group    (best_group),
		.top_total     (top_total),
		.kept          (kept),
		.group_running (group_running),
		.saturated     (saturated),
		.errors        (errors),
		.waiting       (waiting)
	);

	// Receiver: random stalls at the current rate, except during the one long
	// hold-off, when stall stays high until the count from HOLD_LEN runs out.
	always @(posedge clk) begin
		if (hold_req && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_LEN - 1;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	// A random amount from zero up to hi.
	function automatic logic [tkgs_pkg::VAL_W-1:0] rand_upto(int unsigned hi);
		logic [31:0] r;
		r = $urandom_range(hi);
		return r[tkgs_pkg::VAL_W-1:0];
	endfunction

	// Offers one beat, after a random number of idle cycles, and returns at
	// the edge that takes it. The payload holds steady while the block stalls.
	task automatic put_item(input tkgs_pkg::cmd_t c,
		input logic [tkgs_pkg::VAL_W-1:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stops offering and waits until every queued result has come out. The
	// block has no work left once its last result is out; the extra cycles
	// only let the final stall settle.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (waiting != 0);
		repeat (3) @(posedge clk);
	endtask

	// keep_count write; only called while the block is idle.
	task automatic set_keep(input logic [tkgs_pkg::KCNT_W-1:0] k);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= k;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly well-formed groups: a few adds and a close. The amounts come in
	// three flavors: tiny ones so that sums tie often, the two extremes, and
	// the full range. Around them go stray beats of any command, including the
	// unused one, and the odd clear so that the keep fills up again and again.
	task automatic random_items(input int n);
		int                         sent;
		int                         len;
		int                         mode;
		int                         roll;
		logic [1:0]                 c_bits;
		logic [tkgs_pkg::VAL_W-1:0] v;
		sent = 0;
		while (sent < n) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				c_bits = 2'($urandom_range(3));
				put_item(tkgs_pkg::cmd_t'(c_bits), rand_upto(16'hFFFF));
				sent++;
			end else if (roll < 11) begin
				put_item(tkgs_pkg::CMD_CLEAR, rand_upto(16'hFFFF));
				sent++;
			end else begin
				len  = $urandom_range(5);
				mode = $urandom_range(3);
				repeat (len) begin
					case (mode)
						0: v = rand_upto(3);
						1: v = $urandom_range(1) ? '1 : '0;
						default: v = rand_upto(16'hFFFF);
					endcase
					put_item(tkgs_pkg::CMD_ADD, v);
					sent++;
				end
				if ($urandom_range(9) == 0) begin
					put_item(tkgs_pkg::CMD_NONE, rand_upto(16'hFFFF));
					sent++;
				end
				put_item(tkgs_pkg::CMD_CLOSE, rand_upto(16'hFFFF));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset keep size of three. The value of a
		// beat that is not an add must be ignored, so it is set to odd values.
		put_item(tkgs_pkg::CMD_NONE, 16'hFFFF);
		put_item(tkgs_pkg::CMD_CLOSE, 16'hFFFF);    // empty group offers a zero sum
		put_item(tkgs_pkg::CMD_ADD, 16'hFFFF);
		put_item(tkgs_pkg::CMD_ADD, 16'h0000);
		put_item(tkgs_pkg::CMD_ADD, 16'h0001);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h1234);    // group sum 0x10000
		put_item(tkgs_pkg::CMD_ADD, 16'd5);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);    // keep now full
		put_item(tkgs_pkg::CMD_ADD, 16'd7);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);    // replaces the zero
		put_item(tkgs_pkg::CMD_ADD, 16'd5);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);    // equal to the smallest: no change
		put_item(tkgs_pkg::CMD_CLEAR, 16'hA5A5);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);    // three zero sums tie for smallest
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);
		put_item(tkgs_pkg::CMD_ADD, 16'd9);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);    // the lowest of the tied slots goes
		settle();

		// A keep of size zero: closes still raise the largest sum, nothing is
		// kept.
		set_keep(4'd0);
		put_item(tkgs_pkg::CMD_ADD, 16'd4);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);
		put_item(tkgs_pkg::CMD_CLOSE, 16'h0000);
		put_item(tkgs_pkg::CMD_NONE, 16'h5A5A);
		settle();

		// Oversized keep_count acts as the full slot count. Slow receiver.
		set_keep(4'd15);
		send_gap_pct <= 13;
		recv_gap_pct <= 85;
		random_items(260);
		settle();

		// Full slot count with a slow sender. The phase ends with four kept
		// sums so that the next, smaller setting starts with a shrunk keep.
		set_keep(4'd8);
		send_gap_pct <= 85;
		recv_gap_pct <= 13;
		random_items(260);
		put_item(tkgs_pkg::CMD_CLEAR, rand_upto(16'hFFFF));
		repeat (4) begin
			put_item(tkgs_pkg::CMD_ADD, rand_upto(16'hFFFF));
			put_item(tkgs_pkg::CMD_CLOSE, rand_upto(16'hFFFF));
		end
		settle();

		// Keep of two while four are kept: nothing changes in the keep until
		// a clear. Neither side idles; the long hold-off starts right away
		// while the sender keeps offering, so the block backs up.
		set_keep(4'd2);
		send_gap_pct <= 0;
		recv_gap_pct <= 0;
		hold_req     <= 1'b1;
		random_items(130);

		// Large group sums built from the largest amounts; the flag must stay
		// clear below the ceiling and a clear ends the run.
		put_item(tkgs_pkg::CMD_CLEAR, rand_upto(16'hFFFF));
		repeat (40) put_item(tkgs_pkg::CMD_ADD, 16'hFFFF);
		put_item(tkgs_pkg::CMD_ADD, 16'h0000);
		put_item(tkgs_pkg::CMD_ADD, rand_upto(16'hFFFF));
		put_item(tkgs_pkg::CMD_CLOSE, rand_upto(16'hFFFF));
		put_item(tkgs_pkg::CMD_ADD, rand_upto(16'hFFFF));
		put_item(tkgs_pkg::CMD_CLOSE, rand_upto(16'hFFFF));
		put_item(tkgs_pkg::CMD_CLEAR, rand_upto(16'hFFFF));
		settle();

		// A keep of one slot.
		set_keep(4'd1);
		random_items(120);
		settle();

		if (errors == 0 && waiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog, set well beyond the slowest correct run.
	initial begin
		#200000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
sv/tkgs_pkg.sv
sv/tkgs_cell.sv
sv/tkgs_keep.sv
sv/top_k_group_sum_tracker.sv
tb/top_k_group_sum_tracker_check.sv
tb/top_k_group_sum_tracker_test.sv
